[src/go_to_goal_velocity_controller_core_assert.svh]
// Assertion macros shared by the go-to-goal controller RTL.
// Each macro expands to one labeled concurrent assertion with a reset guard.
`ifndef GO_TO_GOAL_VELOCITY_CONTROLLER_CORE_ASSERT_SVH
`define GO_TO_GOAL_VELOCITY_CONTROLLER_CORE_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define GGVC_ASSERT_SAME(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed: %m");

// Consequent checked in the cycle after the antecedent.
`define GGVC_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed: %m");

`endif

[src/ggvc_pkg.sv]
// Shared types, widths, constants and the arctangent table of the go-to-goal controller.
// No dependencies.
package ggvc_pkg;

    localparam int CORDIC_STAGES      = 16;
    localparam int POSITION_FRAC_BITS = 16;

    localparam int POS_W   = 24;
    localparam int HEAD_W  = 16;
    localparam int DIFF_W  = POS_W + 1;
    localparam int XW      = POS_W + 3;
    localparam int ZW      = 28;
    localparam int ATAN_LEN = 24;
    localparam int SHIFT_W = 5;

    localparam int BEAR_SHIFT = 11;
    localparam int BEAR_W     = ZW - BEAR_SHIFT;
    localparam int ERR_W      = 18;

    localparam int DIST_W     = XW - 1;
    localparam int INV_GAIN_W = 16;
    localparam int DGAIN_W    = 16;
    localparam int LIN_RAW_W  = DIST_W + DGAIN_W - POSITION_FRAC_BITS;

    localparam int AGAIN_W    = 12;
    localparam int ALIMIT_W   = 17;
    localparam int LLIMIT_W   = 16;
    localparam int CUTOFF_W   = 15;
    localparam int ANG_SHIFT  = 5;
    localparam int ANG_PROD_W = AGAIN_W + 1 + ERR_W;
    localparam int ANG_RAW_W  = ANG_PROD_W - ANG_SHIFT;

    localparam int FWD_W  = 16;
    localparam int TURN_W = 18;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;

    localparam logic signed [ZW-1:0]    PI_Q24      = ZW'(52707179);
    localparam logic signed [ZW-1:0]    BEAR_ROUND  = ZW'(1 << (BEAR_SHIFT - 1));
    localparam logic signed [ERR_W-1:0] PI_Q13      = ERR_W'(25736);
    localparam logic signed [ERR_W-1:0] TWO_PI_Q13  = ERR_W'(51472);
    localparam logic [INV_GAIN_W-1:0]   INV_GAIN_Q16 = INV_GAIN_W'(39797);
    localparam logic signed [ANG_PROD_W-1:0] ANG_ROUND = ANG_PROD_W'(1 << (ANG_SHIFT - 1));

    localparam logic [AGAIN_W-1:0]  RST_ANGULAR_GAIN   = AGAIN_W'(512);
    localparam logic [ALIMIT_W-1:0] RST_ANGULAR_LIMIT  = ALIMIT_W'(52429);
    localparam logic [LLIMIT_W-1:0] RST_LINEAR_LIMIT   = LLIMIT_W'(13107);
    localparam logic [DGAIN_W-1:0]  RST_DISTANCE_GAIN  = DGAIN_W'(32768);
    localparam logic [CUTOFF_W-1:0] RST_HEADING_CUTOFF = CUTOFF_W'(6434);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ANGULAR_GAIN   = 3'd0,
        CFG_ANGULAR_LIMIT  = 3'd1,
        CFG_LINEAR_LIMIT   = 3'd2,
        CFG_DISTANCE_GAIN  = 3'd3,
        CFG_HEADING_CUTOFF = 3'd4
    } cfg_index_t;

    typedef struct packed {
        logic [AGAIN_W-1:0]  angular_gain;
        logic [ALIMIT_W-1:0] angular_limit;
        logic [LLIMIT_W-1:0] linear_limit;
        logic [DGAIN_W-1:0]  distance_gain;
        logic [CUTOFF_W-1:0] heading_cutoff;
    } cfg_t;

    // Vector state handed from one rotation cell to the next.
    typedef struct packed {
        logic                     zero;
        logic signed [HEAD_W-1:0] heading;
        logic signed [XW-1:0]     x;
        logic signed [XW-1:0]     y;
        logic signed [ZW-1:0]     z;
    } cordic_t;

    // round(atan(2^-i) * 2^24)
    function automatic logic signed [ZW-1:0] atan_entry(input logic [SHIFT_W-1:0] idx);
        logic signed [ZW-1:0] v;
        unique case (idx)
            5'd0:  v = ZW'(13176795);
            5'd1:  v = ZW'(7778716);
            5'd2:  v = ZW'(4110060);
            5'd3:  v = ZW'(2086331);
            5'd4:  v = ZW'(1047214);
            5'd5:  v = ZW'(524117);
            5'd6:  v = ZW'(262123);
            5'd7:  v = ZW'(131069);
            5'd8:  v = ZW'(65536);
            5'd9:  v = ZW'(32768);
            5'd10: v = ZW'(16384);
            5'd11: v = ZW'(8192);
            5'd12: v = ZW'(4096);
            5'd13: v = ZW'(2048);
            5'd14: v = ZW'(1024);
            5'd15: v = ZW'(512);
            5'd16: v = ZW'(256);
            5'd17: v = ZW'(128);
            5'd18: v = ZW'(64);
            5'd19: v = ZW'(32);
            5'd20: v = ZW'(16);
            5'd21: v = ZW'(8);
            5'd22: v = ZW'(4);
            5'd23: v = ZW'(2);
            default: v = '0;
        endcase
        return v;
    endfunction

endpackage

[src/ggvc_if.sv]
// Valid/ready channel interfaces for pose requests and speed command results.
// Depends on ggvc_pkg for field widths.
interface ggvc_pose_if;
    logic                                  valid;
    logic                                  ready;
    logic signed [ggvc_pkg::POS_W-1:0]     robot_pos_x;
    logic signed [ggvc_pkg::POS_W-1:0]     robot_pos_y;
    logic signed [ggvc_pkg::HEAD_W-1:0]    robot_heading;
    logic signed [ggvc_pkg::POS_W-1:0]     target_x;
    logic signed [ggvc_pkg::POS_W-1:0]     target_y;

    modport source (output valid, robot_pos_x, robot_pos_y, robot_heading, target_x, target_y,
                    input ready);
    modport sink (input valid, robot_pos_x, robot_pos_y, robot_heading, target_x, target_y,
                  output ready);
endinterface

interface ggvc_cmd_if;
    logic                                valid;
    logic                                ready;
    logic [ggvc_pkg::FWD_W-1:0]          forward_speed;
    logic signed [ggvc_pkg::TURN_W-1:0]  turn_speed;

    modport source (output valid, forward_speed, turn_speed, input ready);
    modport sink (input valid, forward_speed, turn_speed, output ready);
endinterface

[src/ggvc_prep.sv]
// Front stage: forms the goal offset and folds it into the right half plane.
// Depends on ggvc_pkg.
module ggvc_prep (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                en,
    input  logic                                in_valid,
    input  logic signed [ggvc_pkg::POS_W-1:0]   robot_pos_x,
    input  logic signed [ggvc_pkg::POS_W-1:0]   robot_pos_y,
    input  logic signed [ggvc_pkg::HEAD_W-1:0]  robot_heading,
    input  logic signed [ggvc_pkg::POS_W-1:0]   target_x,
    input  logic signed [ggvc_pkg::POS_W-1:0]   target_y,
    output logic                                out_valid,
    output ggvc_pkg::cordic_t                   out_data
);

    logic signed [ggvc_pkg::DIFF_W-1:0] dx;
    logic signed [ggvc_pkg::DIFF_W-1:0] dy;
    logic signed [ggvc_pkg::XW-1:0]     dx_ext;
    logic signed [ggvc_pkg::XW-1:0]     dy_ext;
    logic                               valid_reg;
    ggvc_pkg::cordic_t                  data_reg;
    ggvc_pkg::cordic_t                  data_next;

    assign dx     = ggvc_pkg::DIFF_W'(target_x) - ggvc_pkg::DIFF_W'(robot_pos_x);
    assign dy     = ggvc_pkg::DIFF_W'(target_y) - ggvc_pkg::DIFF_W'(robot_pos_y);
    assign dx_ext = ggvc_pkg::XW'(dx);
    assign dy_ext = ggvc_pkg::XW'(dy);

    // A vector in the left half plane is negated and the angle starts at plus or minus pi.
    always_comb
    begin
        data_next.zero    = (dx == '0) && (dy == '0);
        data_next.heading = robot_heading;
        if (dx[ggvc_pkg::DIFF_W-1])
        begin
            data_next.x = -dx_ext;
            data_next.y = -dy_ext;
            data_next.z = dy[ggvc_pkg::DIFF_W-1] ? -ggvc_pkg::PI_Q24 : ggvc_pkg::PI_Q24;
        end
        else
        begin
            data_next.x = dx_ext;
            data_next.y = dy_ext;
            data_next.z = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

[src/ggvc_cordic_cell.sv]
// One vectoring rotation cell of the CORDIC chain, registered at its output.
// Depends on ggvc_pkg for the vector type and the arctangent table.
module ggvc_cordic_cell (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            en,
    input  logic [ggvc_pkg::SHIFT_W-1:0]    shift,
    input  logic                            in_valid,
    input  ggvc_pkg::cordic_t               in_data,
    output logic                            out_valid,
    output ggvc_pkg::cordic_t               out_data
);

    logic signed [ggvc_pkg::XW-1:0] x_in;
    logic signed [ggvc_pkg::XW-1:0] y_in;
    logic signed [ggvc_pkg::XW-1:0] x_sh;
    logic signed [ggvc_pkg::XW-1:0] y_sh;
    logic signed [ggvc_pkg::ZW-1:0] step_angle;
    logic                           valid_reg;
    ggvc_pkg::cordic_t              data_reg;
    ggvc_pkg::cordic_t              data_next;

    assign x_in       = in_data.x;
    assign y_in       = in_data.y;
    assign x_sh       = x_in >>> shift;
    assign y_sh       = y_in >>> shift;
    assign step_angle = ggvc_pkg::atan_entry(shift);

    // Rotate toward the x axis; a non-negative y turns clockwise.
    always_comb
    begin
        data_next.zero    = in_data.zero;
        data_next.heading = in_data.heading;
        if (!y_in[ggvc_pkg::XW-1])
        begin
            data_next.x = x_in + y_sh;
            data_next.y = y_in - x_sh;
            data_next.z = in_data.z + step_angle;
        end
        else
        begin
            data_next.x = x_in - y_sh;
            data_next.y = y_in + x_sh;
            data_next.z = in_data.z - step_angle;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (en)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

[src/ggvc_post.sv]
// Back end: bearing error wrap, gain products, clamping and the output register.
// Depends on ggvc_pkg and the assertion macro header.
`include "go_to_goal_velocity_controller_core_assert.svh"

module ggvc_post (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                en,
    input  logic                                in_valid,
    input  ggvc_pkg::cordic_t                   in_data,
    input  ggvc_pkg::cfg_t                      cfg,
    output logic                                out_valid,
    output logic [ggvc_pkg::FWD_W-1:0]          forward_speed,
    output logic signed [ggvc_pkg::TURN_W-1:0]  turn_speed
);

    function automatic logic signed [ggvc_pkg::ERR_W-1:0] wrap_step(
        input logic signed [ggvc_pkg::ERR_W-1:0] e
    );
        logic signed [ggvc_pkg::ERR_W-1:0] r;
        if (e > ggvc_pkg::PI_Q13)
        begin
            r = e - ggvc_pkg::TWO_PI_Q13;
        end
        else if (e < -ggvc_pkg::PI_Q13)
        begin
            r = e + ggvc_pkg::TWO_PI_Q13;
        end
        else
        begin
            r = e;
        end
        return r;
    endfunction

    // Stage A: bearing, wrapped error and distance.
    logic signed [ggvc_pkg::ZW-1:0]                      z_round;
    logic signed [ggvc_pkg::BEAR_W-1:0]                  bearing;
    logic signed [ggvc_pkg::ERR_W-1:0]                   err_raw;
    logic signed [ggvc_pkg::ERR_W-1:0]                   err_next;
    logic [ggvc_pkg::DIST_W+ggvc_pkg::INV_GAIN_W-1:0]    dist_prod;
    logic [ggvc_pkg::DIST_W-1:0]                         dist_next;
    logic                                                a_valid_reg;
    logic signed [ggvc_pkg::ERR_W-1:0]                   a_err_reg;
    logic [ggvc_pkg::DIST_W-1:0]                         a_dist_reg;

    assign z_round  = in_data.z + ggvc_pkg::BEAR_ROUND;
    assign bearing  = in_data.zero ? '0 : ggvc_pkg::BEAR_W'(z_round >>> ggvc_pkg::BEAR_SHIFT);
    assign err_raw  = ggvc_pkg::ERR_W'(bearing) - ggvc_pkg::ERR_W'(in_data.heading);
    assign err_next = wrap_step(wrap_step(err_raw));
    assign dist_prod = in_data.x[ggvc_pkg::DIST_W-1:0] * ggvc_pkg::INV_GAIN_Q16;
    assign dist_next = in_data.zero ? '0 :
        dist_prod[ggvc_pkg::DIST_W+ggvc_pkg::INV_GAIN_W-1:ggvc_pkg::INV_GAIN_W];

    // Stage B: angular product, distance product and the cutoff test.
    logic signed [ggvc_pkg::ANG_PROD_W-1:0]              gain_ext;
    logic signed [ggvc_pkg::ANG_PROD_W-1:0]              err_ext;
    logic signed [ggvc_pkg::ANG_PROD_W-1:0]              ang_prod;
    logic signed [ggvc_pkg::ANG_PROD_W-1:0]              ang_rounded;
    logic [ggvc_pkg::DIST_W+ggvc_pkg::DGAIN_W-1:0]       lin_prod;
    logic [ggvc_pkg::ERR_W-1:0]                          err_mag;
    logic                                                b_valid_reg;
    logic signed [ggvc_pkg::ANG_RAW_W-1:0]               b_ang_reg;
    logic [ggvc_pkg::LIN_RAW_W-1:0]                      b_lin_reg;
    logic                                                b_far_reg;

    assign gain_ext    = ggvc_pkg::ANG_PROD_W'(signed'({1'b0, cfg.angular_gain}));
    assign err_ext     = ggvc_pkg::ANG_PROD_W'(a_err_reg);
    assign ang_prod    = gain_ext * err_ext;
    assign ang_rounded = ang_prod + ggvc_pkg::ANG_ROUND;
    assign lin_prod    = a_dist_reg * cfg.distance_gain;
    assign err_mag     = a_err_reg[ggvc_pkg::ERR_W-1] ? ggvc_pkg::ERR_W'(-a_err_reg)
                                                      : ggvc_pkg::ERR_W'(a_err_reg);

    // Stage C: saturation and the output register.
    logic signed [ggvc_pkg::ANG_RAW_W-1:0]               lim_pos;
    logic signed [ggvc_pkg::ANG_RAW_W-1:0]               ang_clamped;
    logic [ggvc_pkg::FWD_W-1:0]                          fwd_next;
    logic                                                out_valid_reg;
    logic [ggvc_pkg::FWD_W-1:0]                          fwd_reg;
    logic signed [ggvc_pkg::TURN_W-1:0]                  turn_reg;

    assign lim_pos = ggvc_pkg::ANG_RAW_W'(signed'({1'b0, cfg.angular_limit}));

    always_comb
    begin
        priority if (b_ang_reg > lim_pos)
        begin
            ang_clamped = lim_pos;
        end
        else if (b_ang_reg < -lim_pos)
        begin
            ang_clamped = -lim_pos;
        end
        else
        begin
            ang_clamped = b_ang_reg;
        end
    end

    always_comb
    begin
        priority if (b_far_reg)
        begin
            fwd_next = '0;
        end
        else if (b_lin_reg > ggvc_pkg::LIN_RAW_W'(cfg.linear_limit))
        begin
            fwd_next = cfg.linear_limit;
        end
        else
        begin
            fwd_next = b_lin_reg[ggvc_pkg::FWD_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg   <= 1'b0;
            b_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg   <= in_valid;
            b_valid_reg   <= a_valid_reg;
            out_valid_reg <= b_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_err_reg  <= err_next;
            a_dist_reg <= dist_next;
            b_ang_reg  <= ang_rounded[ggvc_pkg::ANG_PROD_W-1:ggvc_pkg::ANG_SHIFT];
            b_lin_reg  <= lin_prod[ggvc_pkg::DIST_W+ggvc_pkg::DGAIN_W-1:
                                   ggvc_pkg::POSITION_FRAC_BITS];
            b_far_reg  <= err_mag > ggvc_pkg::ERR_W'(cfg.heading_cutoff);
            fwd_reg    <= fwd_next;
            turn_reg   <= ggvc_pkg::TURN_W'(ang_clamped);
        end
    end

    assign out_valid     = out_valid_reg;
    assign forward_speed = fwd_reg;
    assign turn_speed    = turn_reg;

    `GGVC_ASSERT_NEXT(a_far_gives_stop, clk, rst_n, en && b_valid_reg && b_far_reg, fwd_reg == '0)
    `GGVC_ASSERT_NEXT(a_fwd_within_limit, clk, rst_n, en && b_valid_reg, fwd_reg <= $past(cfg.linear_limit))
    `GGVC_ASSERT_NEXT(a_turn_within_limit, clk, rst_n, en && b_valid_reg, (turn_reg <= $signed({1'b0, $past(cfg.angular_limit)})) && (turn_reg >= -$signed({1'b0, $past(cfg.angular_limit)})))

endmodule

[src/go_to_goal_velocity_controller_core.sv]
// Go-to-goal velocity controller: pose request in, forward and turn speed command out.
// The pipeline is one front stage, one cell per CORDIC iteration, and three back-end
// stages ending in the output register.
// Throughput is one request per cycle; the whole pipeline advances whenever the output
// register is empty or being taken, so a stalled result holds every stage in place.
// rst_n clears all valid bits and loads the configuration registers with their defaults.
module go_to_goal_velocity_controller_core (
    input  logic                                    clk,
    input  logic                                    rst_n,
    ggvc_pose_if.sink                               pose,
    ggvc_cmd_if.source                              cmd,
    input  logic                                    cfg_we,
    input  logic [ggvc_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [ggvc_pkg::CFG_DATA_W-1:0]         cfg_data
);

    // Configuration registers. Writes to an index with no register are dropped.
    ggvc_pkg::cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.angular_gain   <= ggvc_pkg::RST_ANGULAR_GAIN;
            cfg_reg.angular_limit  <= ggvc_pkg::RST_ANGULAR_LIMIT;
            cfg_reg.linear_limit   <= ggvc_pkg::RST_LINEAR_LIMIT;
            cfg_reg.distance_gain  <= ggvc_pkg::RST_DISTANCE_GAIN;
            cfg_reg.heading_cutoff <= ggvc_pkg::RST_HEADING_CUTOFF;
        end
        else if (cfg_we)
        begin
            unique case (ggvc_pkg::cfg_index_t'(cfg_index))
                ggvc_pkg::CFG_ANGULAR_GAIN:
                begin
                    cfg_reg.angular_gain <= cfg_data[ggvc_pkg::AGAIN_W-1:0];
                end
                ggvc_pkg::CFG_ANGULAR_LIMIT:
                begin
                    cfg_reg.angular_limit <= cfg_data[ggvc_pkg::ALIMIT_W-1:0];
                end
                ggvc_pkg::CFG_LINEAR_LIMIT:
                begin
                    cfg_reg.linear_limit <= cfg_data[ggvc_pkg::LLIMIT_W-1:0];
                end
                ggvc_pkg::CFG_DISTANCE_GAIN:
                begin
                    cfg_reg.distance_gain <= cfg_data[ggvc_pkg::DGAIN_W-1:0];
                end
                ggvc_pkg::CFG_HEADING_CUTOFF:
                begin
                    cfg_reg.heading_cutoff <= cfg_data[ggvc_pkg::CUTOFF_W-1:0];
                end
                default:
                begin
                    cfg_reg <= cfg_reg;
                end
            endcase
        end
    end

    // One enable moves every stage. The output register frees up either when it is
    // empty or when the consumer takes its result in this cycle, so a new request can
    // enter at the same edge a finished command leaves.
    logic advance;
    logic out_valid;

    assign advance    = !out_valid || cmd.ready;
    assign pose.ready = advance;

    // Front stage: offset to the goal and half-plane folding.
    logic              prep_valid;
    ggvc_pkg::cordic_t prep_data;

    ggvc_prep u_prep (
        .clk           (clk),
        .rst_n         (rst_n),
        .en            (advance),
        .in_valid      (pose.valid),
        .robot_pos_x   (pose.robot_pos_x),
        .robot_pos_y   (pose.robot_pos_y),
        .robot_heading (pose.robot_heading),
        .target_x      (pose.target_x),
        .target_y      (pose.target_y),
        .out_valid     (prep_valid),
        .out_data      (prep_data)
    );

    // Chain of rotation cells. Cell i shifts by i and uses the i-th arctangent entry;
    // each cell hands its rotated vector and accumulated angle to the next whenever the pipeline advances.
    logic              chain_valid [ggvc_pkg::CORDIC_STAGES+1];
    ggvc_pkg::cordic_t chain_data  [ggvc_pkg::CORDIC_STAGES+1];

    assign chain_valid[0] = prep_valid;
    assign chain_data[0]  = prep_data;

    for (genvar i = 0; i < ggvc_pkg::CORDIC_STAGES; i++)
    begin : g_cell
        ggvc_cordic_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .en        (advance),
            .shift     (ggvc_pkg::SHIFT_W'(i)),
            .in_valid  (chain_valid[i]),
            .in_data   (chain_data[i]),
            .out_valid (chain_valid[i+1]),
            .out_data  (chain_data[i+1])
        );
    end

    // Back end: bearing error, gains, saturation and the output register.
    ggvc_post u_post (
        .clk           (clk),
        .rst_n         (rst_n),
        .en            (advance),
        .in_valid      (chain_valid[ggvc_pkg::CORDIC_STAGES]),
        .in_data       (chain_data[ggvc_pkg::CORDIC_STAGES]),
        .cfg           (cfg_reg),
        .out_valid     (out_valid),
        .forward_speed (cmd.forward_speed),
        .turn_speed    (cmd.turn_speed)
    );

    assign cmd.valid = out_valid;

endmodule
